/* src/ovtr_pkg.sv */
// Shared types and constants of the overvoltage alarm and trip relay.
`default_nettype none
package ovtr_pkg;

  localparam int PHASES   = 3;
  localparam int VOLT_W   = 16;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [VOLT_W-1:0] ALARM_LIMIT_RST = 16'd65535;
  localparam logic [TICK_W-1:0] ALARM_DELAY_RST = 16'd100;
  localparam logic [VOLT_W-1:0] TRIP_LIMIT_RST  = 16'd65535;
  localparam logic [TICK_W-1:0] TRIP_DELAY_RST  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALARM_LIMIT = 2'd0,
    REG_ALARM_DELAY = 2'd1,
    REG_TRIP_LIMIT  = 2'd2,
    REG_TRIP_DELAY  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [VOLT_W-1:0] alarm_limit;
    logic [TICK_W-1:0] alarm_need;
    logic [VOLT_W-1:0] trip_limit;
    logic [TICK_W-1:0] trip_need;
  } relay_cfg_t;

  typedef struct packed {
    logic trip_due;
    logic alarm_flag;
  } lane_stat_t;

  typedef struct packed {
    logic              trip;
    logic [PHASES-1:0] trip_phases;
    logic [PHASES-1:0] alarm_phases;
  } relay_res_t;

  // A delay of zero behaves as a delay of one tick.
  function automatic logic [TICK_W-1:0] delay_need(input logic [TICK_W-1:0] d);
    return (d == '0) ? TICK_W'(1) : d;
  endfunction

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] t);
    return (t == TICK_MAX) ? t : t + TICK_W'(1);
  endfunction

endpackage
`default_nettype wire

/* src/ovtr_lane.sv */
// One phase lane: alarm and trip timers with band classification.
`default_nettype none
module ovtr_lane
  import ovtr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [VOLT_W-1:0] voltage,
  input  wire relay_cfg_t        cfg,
  output lane_stat_t             stat
);

  logic              trip_run_r,    trip_run_nxt;
  logic [TICK_W-1:0] trip_ticks_r,  trip_ticks_nxt;
  logic              alarm_run_r,   alarm_run_nxt;
  logic [TICK_W-1:0] alarm_ticks_r, alarm_ticks_nxt;

  always_comb begin
    trip_run_nxt    = trip_run_r;
    trip_ticks_nxt  = trip_ticks_r;
    alarm_run_nxt   = alarm_run_r;
    alarm_ticks_nxt = alarm_ticks_r;
    if (step) begin
      if (voltage > cfg.trip_limit) begin
        trip_run_nxt   = 1'b1;
        trip_ticks_nxt = trip_run_r ? sat_inc(trip_ticks_r) : '0;
        if (alarm_run_r) begin
          alarm_ticks_nxt = sat_inc(alarm_ticks_r);
        end
      end else if (voltage >= cfg.alarm_limit) begin
        trip_run_nxt    = 1'b0;
        trip_ticks_nxt  = '0;
        alarm_run_nxt   = 1'b1;
        alarm_ticks_nxt = alarm_run_r ? sat_inc(alarm_ticks_r) : '0;
      end else begin
        trip_run_nxt    = 1'b0;
        trip_ticks_nxt  = '0;
        alarm_run_nxt   = 1'b0;
        alarm_ticks_nxt = '0;
      end
    end
  end

  always_comb begin
    stat.trip_due   = trip_run_nxt && (trip_ticks_nxt >= cfg.trip_need);
    stat.alarm_flag = !trip_run_nxt && alarm_run_nxt &&
                      (alarm_ticks_nxt >= cfg.alarm_need);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_run_r    <= 1'b0;
      trip_ticks_r  <= '0;
      alarm_run_r   <= 1'b0;
      alarm_ticks_r <= '0;
    end else begin
      trip_run_r    <= trip_run_nxt;
      trip_ticks_r  <= trip_ticks_nxt;
      alarm_run_r   <= alarm_run_nxt;
      alarm_ticks_r <= alarm_ticks_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/ovtr_merge.sv */
// Merge of lane status: trip latch and assembly of the result.
`default_nettype none
module ovtr_merge
  import ovtr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire lane_stat_t stat [PHASES],
  output logic            latched,
  output relay_res_t      res
);

  logic              latched_r, latched_nxt;
  logic [PHASES-1:0] phases_r,  phases_nxt;
  logic [PHASES-1:0] due;
  logic [PHASES-1:0] alarms;

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      due[p]    = stat[p].trip_due;
      alarms[p] = stat[p].alarm_flag;
    end
  end

  always_comb begin
    latched_nxt = latched_r;
    phases_nxt  = phases_r;
    // latch every phase that comes due on the same tick
    if (step && (due != '0)) begin
      latched_nxt = 1'b1;
      phases_nxt  = due;
    end
  end

  always_comb begin
    latched          = latched_r;
    res.trip         = latched_nxt;
    res.trip_phases  = phases_nxt;
    res.alarm_phases = alarms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r <= 1'b0;
      phases_r  <= '0;
    end else begin
      latched_r <= latched_nxt;
      phases_r  <= phases_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/overvoltage_alarm_trip_relay_core.sv */
// Top level of the three-phase definite-time overvoltage alarm and trip relay.
// The result of a request is loaded into the output register on the edge that accepts it,
//   so out_valid rises in the cycle after acceptance.
// Throughput: one request per cycle; in_stall is high only while a result waits in
//   the output register and the consumer stalls it.
// Reset (rst_n low, synchronous): timers, trip latch and output valid clear; the
//   limit and delay registers return to their defaults.
`default_nettype none
module overvoltage_alarm_trip_relay_core
  import ovtr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VOLT_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [VOLT_W-1:0]    in_phase_a_voltage,
  input  wire logic [VOLT_W-1:0]    in_phase_b_voltage,
  input  wire logic [VOLT_W-1:0]    in_phase_c_voltage,
  input  wire logic                 in_breaker_closed,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_trip,
  output logic [PHASES-1:0]         out_trip_phases,
  output logic [PHASES-1:0]         out_alarm_phases
);

  // Configuration registers; the delays are held as written and mapped to the tick count that makes a timer due.
  logic [VOLT_W-1:0] alarm_limit_r, alarm_limit_nxt;
  logic [TICK_W-1:0] alarm_delay_r, alarm_delay_nxt;
  logic [VOLT_W-1:0] trip_limit_r,  trip_limit_nxt;
  logic [TICK_W-1:0] trip_delay_r,  trip_delay_nxt;
  relay_cfg_t        cfg;

  always_comb begin
    alarm_limit_nxt = alarm_limit_r;
    alarm_delay_nxt = alarm_delay_r;
    trip_limit_nxt  = trip_limit_r;
    trip_delay_nxt  = trip_delay_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ALARM_LIMIT: alarm_limit_nxt = cfg_wdata;
        REG_ALARM_DELAY: alarm_delay_nxt = cfg_wdata;
        REG_TRIP_LIMIT:  trip_limit_nxt  = cfg_wdata;
        REG_TRIP_DELAY:  trip_delay_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_limit_r <= ALARM_LIMIT_RST;
      alarm_delay_r <= ALARM_DELAY_RST;
      trip_limit_r  <= TRIP_LIMIT_RST;
      trip_delay_r  <= TRIP_DELAY_RST;
    end else begin
      alarm_limit_r <= alarm_limit_nxt;
      alarm_delay_r <= alarm_delay_nxt;
      trip_limit_r  <= trip_limit_nxt;
      trip_delay_r  <= trip_delay_nxt;
    end
  end

  always_comb begin
    cfg.alarm_limit = alarm_limit_r;
    cfg.alarm_need  = delay_need(alarm_delay_r);
    cfg.trip_limit  = trip_limit_r;
    cfg.trip_need   = delay_need(trip_delay_r);
  end

  // Handshake: accept whenever the output register is empty or drains this cycle.
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic latched;
  logic lane_step;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  // An open breaker or a latched trip freezes every timer; outputs show held state.
  assign lane_step = accept && in_breaker_closed && !latched;

  logic [VOLT_W-1:0] volt [PHASES];
  lane_stat_t        stat [PHASES];

  always_comb begin
    volt[0] = in_phase_a_voltage;
    volt[1] = in_phase_b_voltage;
    volt[2] = in_phase_c_voltage;
  end

  // One timer lane per phase, all advancing on the same tick.
  for (genvar p = 0; p < PHASES; p++) begin : g_lane
    ovtr_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .step    (lane_step),
      .voltage (volt[p]),
      .cfg     (cfg),
      .stat    (stat[p])
    );
  end

  relay_res_t res;

  ovtr_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (lane_step),
    .stat    (stat),
    .latched (latched),
    .res     (res)
  );

  // Output register: load on accept, drop valid once the consumer takes the result.
  relay_res_t res_r, res_nxt;

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      res_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_trip         = res_r.trip;
  assign out_trip_phases  = res_r.trip_phases;
  assign out_alarm_phases = res_r.alarm_phases;

endmodule
`default_nettype wire

/* dv/relay_result_checker.sv */
// Checker that predicts and compares the overvoltage relay's per-tick results.
module relay_result_checker
  import ovtr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VOLT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [VOLT_W-1:0]    in_phase_a_voltage,
  input  logic [VOLT_W-1:0]    in_phase_b_voltage,
  input  logic [VOLT_W-1:0]    in_phase_c_voltage,
  input  logic                 in_breaker_closed,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_trip,
  input  logic [PHASES-1:0]    out_trip_phases,
  input  logic [PHASES-1:0]    out_alarm_phases,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // settings as last written
  logic [VOLT_W-1:0] lim_alarm;
  logic [VOLT_W-1:0] lim_trip;
  logic [TICK_W-1:0] dly_alarm;
  logic [TICK_W-1:0] dly_trip;

  // per-phase timers and the trip latch
  logic [PHASES-1:0]             alm_on;
  logic [PHASES-1:0]             trp_on;
  logic [PHASES-1:0][TICK_W-1:0] alm_cnt;
  logic [PHASES-1:0][TICK_W-1:0] trp_cnt;
  logic                          tripped;
  logic [PHASES-1:0]             tripped_phases;

  relay_res_t pending_results[$];
  relay_res_t want_res;
  int         result_index;

  function automatic logic [TICK_W-1:0] count_up(input logic [TICK_W-1:0] cnt);
    return (cnt == {TICK_W{1'b1}}) ? cnt : cnt + TICK_W'(1);
  endfunction

  // zero delay counts as one tick
  function automatic logic timer_due(input logic on, input logic [TICK_W-1:0] cnt,
                                     input logic [TICK_W-1:0] dly);
    return on && (cnt >= ((dly == '0) ? TICK_W'(1) : dly));
  endfunction

  function automatic relay_res_t relay_tick(input logic [PHASES-1:0][VOLT_W-1:0] volts,
                                            input logic closed);
    relay_res_t        res;
    logic [PHASES-1:0] due;
    int                p;
    due = '0;
    if (closed && !tripped) begin
      for (p = 0; p < PHASES; p++) begin
        if (volts[p] > lim_trip) begin
          if (trp_on[p]) begin
            trp_cnt[p] = count_up(trp_cnt[p]);
          end else begin
            trp_on[p]  = 1'b1;
            trp_cnt[p] = '0;
          end
          // alarm timer keeps counting above the trip limit
          if (alm_on[p]) alm_cnt[p] = count_up(alm_cnt[p]);
        end else if (volts[p] >= lim_alarm) begin
          trp_on[p]  = 1'b0;
          trp_cnt[p] = '0;
          if (alm_on[p]) begin
            alm_cnt[p] = count_up(alm_cnt[p]);
          end else begin
            alm_on[p]  = 1'b1;
            alm_cnt[p] = '0;
          end
        end else begin
          trp_on[p]  = 1'b0;
          trp_cnt[p] = '0;
          alm_on[p]  = 1'b0;
          alm_cnt[p] = '0;
        end
        due[p] = timer_due(trp_on[p], trp_cnt[p], dly_trip);
      end
      if (due != '0) begin
        tripped        = 1'b1;
        tripped_phases = due;
      end
    end
    res.trip        = tripped;
    res.trip_phases = tripped_phases;
    for (p = 0; p < PHASES; p++) begin
      res.alarm_phases[p] = !trp_on[p] && timer_due(alm_on[p], alm_cnt[p], dly_alarm);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_alarm      = ALARM_LIMIT_RST;
      dly_alarm      = ALARM_DELAY_RST;
      lim_trip       = TRIP_LIMIT_RST;
      dly_trip       = TRIP_DELAY_RST;
      alm_on         = '0;
      trp_on         = '0;
      alm_cnt        = '0;
      trp_cnt        = '0;
      tripped        = 1'b0;
      tripped_phases = '0;
      result_index   = 0;
      pending_results.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ALARM_LIMIT: lim_alarm = cfg_wdata;
          REG_ALARM_DELAY: dly_alarm = cfg_wdata;
          REG_TRIP_LIMIT:  lim_trip  = cfg_wdata;
          REG_TRIP_DELAY:  dly_trip  = cfg_wdata;
          default: ;
        endcase
      end
      // retire first: a result leaving now belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result %0d: trip=%0b trip_phases=%b alarm_phases=%b",
                     result_index, out_trip, out_trip_phases, out_alarm_phases);
          end
          fail_count <= fail_count + 1;
        end else begin
          want_res = pending_results.pop_front();
          if (out_trip !== want_res.trip || out_trip_phases !== want_res.trip_phases ||
              out_alarm_phases !== want_res.alarm_phases) begin
            if (fail_count < 10) begin
              $display("result %0d: expected trip=%0b trip_phases=%b alarm_phases=%b",
                       result_index, want_res.trip, want_res.trip_phases,
                       want_res.alarm_phases);
              $display("result %0d: actual   trip=%0b trip_phases=%b alarm_phases=%b",
                       result_index, out_trip, out_trip_phases, out_alarm_phases);
            end
            fail_count <= fail_count + 1;
          end
        end
        result_index++;
      end
      if (in_valid && !in_stall) begin
        pending_results.insert(pending_results.size(),
                               relay_tick({in_phase_c_voltage, in_phase_b_voltage,
                                           in_phase_a_voltage}, in_breaker_closed));
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Top of the overvoltage relay testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ovtr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // voltage classes for the random requests; a class is held for a run of ticks
  typedef enum int {
    LV_BELOW,
    LV_BAND,
    LV_AT_ALARM,
    LV_AT_TRIP,
    LV_ABOVE,
    LV_ZERO,
    LV_FULL
  } level_t;

  logic                 clk                = 1'b0;
  logic                 rst_n              = 1'b0;
  logic                 cfg_we             = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index          = REG_ALARM_LIMIT;
  logic [VOLT_W-1:0]    cfg_wdata          = '0;
  logic                 in_valid           = 1'b0;
  logic [VOLT_W-1:0]    in_phase_a_voltage = '0;
  logic [VOLT_W-1:0]    in_phase_b_voltage = '0;
  logic [VOLT_W-1:0]    in_phase_c_voltage = '0;
  logic                 in_breaker_closed  = 1'b0;
  logic                 out_stall          = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_trip;
  logic [PHASES-1:0]    out_trip_phases;
  logic [PHASES-1:0]    out_alarm_phases;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // limits as last programmed, used to aim the random voltages at the bands
  logic [VOLT_W-1:0] set_alarm_lim = ALARM_LIMIT_RST;
  logic [VOLT_W-1:0] set_trip_lim  = TRIP_LIMIT_RST;

  level_t lane_level [PHASES];
  int     lane_run   [PHASES];

  overvoltage_alarm_trip_relay_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_phase_a_voltage (in_phase_a_voltage),
    .in_phase_b_voltage (in_phase_b_voltage),
    .in_phase_c_voltage (in_phase_c_voltage),
    .in_breaker_closed  (in_breaker_closed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trip           (out_trip),
    .out_trip_phases    (out_trip_phases),
    .out_alarm_phases   (out_alarm_phases)
  );

  relay_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_phase_a_voltage (in_phase_a_voltage),
    .in_phase_b_voltage (in_phase_b_voltage),
    .in_phase_c_voltage (in_phase_c_voltage),
    .in_breaker_closed  (in_breaker_closed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_trip           (out_trip),
    .out_trip_phases    (out_trip_phases),
    .out_alarm_phases   (out_alarm_phases),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  // Receiver side: stall at random, at the current rate; hold off during reset.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request and hold it until accepted. Valid is only dropped when
  // the sender decides to idle, so back-to-back requests keep it high.
  task automatic send_tick(input logic [VOLT_W-1:0] va, input logic [VOLT_W-1:0] vb,
                           input logic [VOLT_W-1:0] vc, input logic closed);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid           <= 1'b1;
    in_phase_a_voltage <= va;
    in_phase_b_voltage <= vb;
    in_phase_c_voltage <= vc;
    in_breaker_closed  <= closed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid, wait until every request's result has come back, then pause.
  // The wait loop waits on the clock before it tests, so valid is never lowered and raised in one step.
  task automatic drain_results(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Program all four registers on back-to-back edges; call only while idle.
  task automatic write_setting(input logic [VOLT_W-1:0] alarm_lim,
                               input logic [TICK_W-1:0] alarm_dly,
                               input logic [VOLT_W-1:0] trip_lim,
                               input logic [TICK_W-1:0] trip_dly);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ALARM_LIMIT;
    cfg_wdata <= alarm_lim;
    @(posedge clk);
    cfg_index <= REG_ALARM_DELAY;
    cfg_wdata <= alarm_dly;
    @(posedge clk);
    cfg_index <= REG_TRIP_LIMIT;
    cfg_wdata <= trip_lim;
    @(posedge clk);
    cfg_index <= REG_TRIP_DELAY;
    cfg_wdata <= trip_dly;
    @(posedge clk);
    cfg_we        <= 1'b0;
    set_alarm_lim  = alarm_lim;
    set_trip_lim   = trip_lim;
  endtask

  // Random limits, sometimes with the trip limit under the alarm limit. The trip
  // delay stays far above any above-trip run here, since a trip freezes the relay
  // for the rest of the run; alarm delays are short so alarms come due often.
  task automatic random_setting();
    logic [VOLT_W-1:0] alarm_lim;
    logic [VOLT_W-1:0] trip_lim;
    alarm_lim = VOLT_W'($urandom_range(50000));
    if ($urandom_range(3) == 0) begin
      trip_lim = VOLT_W'($urandom_range(alarm_lim));
    end else begin
      trip_lim = VOLT_W'($urandom_range(65535, alarm_lim));
    end
    write_setting(alarm_lim, TICK_W'($urandom_range(10)), trip_lim,
                  TICK_W'($urandom_range(65535, 1000)));
  endtask

  function automatic logic [VOLT_W-1:0] level_volt(input level_t lv);
    case (lv)
      LV_BELOW: begin
        return (set_alarm_lim == '0) ? '0 : VOLT_W'($urandom_range(set_alarm_lim - 1));
      end
      LV_BAND: begin
        if (set_alarm_lim <= set_trip_lim) begin
          return VOLT_W'($urandom_range(set_trip_lim, set_alarm_lim));
        end
        return VOLT_W'($urandom_range(65535));
      end
      LV_AT_ALARM: return set_alarm_lim;
      LV_AT_TRIP:  return set_trip_lim;
      LV_ABOVE: begin
        if (set_trip_lim == '1) return '1;
        return VOLT_W'($urandom_range(65535, set_trip_lim + 1));
      end
      LV_ZERO: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly held voltage runs per phase, so timers get to run and come due; now
  // and then a fully random request as noise. The breaker opens now and then.
  task automatic random_tick();
    logic [PHASES-1:0][VOLT_W-1:0] volts;
    int                            p;
    for (p = 0; p < PHASES; p++) begin
      if (lane_run[p] == 0) begin
        lane_level[p] = level_t'($urandom_range(LV_FULL));
        lane_run[p]   = $urandom_range(12, 1);
      end
      lane_run[p] = lane_run[p] - 1;
      volts[p]    = level_volt(lane_level[p]);
    end
    if ($urandom_range(9) == 0) begin
      for (p = 0; p < PHASES; p++) volts[p] = VOLT_W'($urandom);
    end
    send_tick(volts[0], volts[1], volts[2], $urandom_range(11) != 0);
  endtask

  initial begin
    int phase;
    int k;
    for (k = 0; k < PHASES; k++) begin
      lane_level[k] = LV_ZERO;
      lane_run[k]   = 0;
    end

    // hold reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 26;
    recv_stall_pct = 87;

    // Alarm limit at zero: every voltage sits in the alarm band; a zero delay
    // comes due on the tick after the start; an open breaker holds the flags.
    write_setting(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_tick(16'd0, 16'hFFFF, 16'd32768, 1'b1);
    send_tick(16'd0, 16'hFFFF, 16'd32768, 1'b1);
    send_tick(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);

    // Ordinary bands: a voltage equal to the trip limit counts as alarm band;
    // the alarm timer keeps counting above the trip limit but its flag is
    // masked while the trip timer runs.
    drain_results(2);
    write_setting(16'd1000, 16'd2, 16'd2000, 16'hFFFF);
    send_tick(16'd999, 16'd1000, 16'd2000, 1'b1);
    send_tick(16'd1000, 16'd1000, 16'd2000, 1'b1);
    send_tick(16'd1000, 16'd1000, 16'd2000, 1'b1);
    send_tick(16'd2001, 16'hFFFF, 16'd2000, 1'b1);
    send_tick(16'd2000, 16'd1000, 16'd1999, 1'b1);
    send_tick(16'd0, 16'd0, 16'd0, 1'b1);

    // Trip limit under the alarm limit: the alarm band is empty.
    drain_results(2);
    write_setting(16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
    send_tick(16'd0, 16'd1, 16'hFFFF, 1'b1);
    send_tick(16'd0, 16'd0, 16'd1, 1'b1);
    send_tick(16'hFFFF, 16'd0, 16'd0, 1'b1);

    // Random requests in three idling regimes; new limits every 50 requests.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 26 : (phase == 1) ? 87 : 0;
      recv_stall_pct = (phase == 0) ? 87 : (phase == 1) ? 26 : 0;
      for (k = 0; k < 150; k++) begin
        if (k % 50 == 0) begin
          drain_results(2);
          random_setting();
        end else if ($urandom_range(39) == 0) begin
          // let the pipe run dry before the next request
          drain_results(0);
        end
        random_tick();
      end
    end

    // Short soak in the alarm band: phases A and B stay in the band, so their
    // alarms come due after the delay and stay up. Phase C wanders freely, so
    // above-trip runs stay far too short to trip.
    drain_results(2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_setting(16'd20000, 16'd16, 16'd40000, 16'hFFFF);
    for (k = 0; k < 24; k++) begin
      send_tick(VOLT_W'($urandom_range(40000, 20000)), VOLT_W'($urandom_range(40000, 20000)),
                VOLT_W'($urandom), 1'b1);
    end

    // Trip last, since it latches until reset. A single tick above the trip limit
    // does not trip with a zero delay; two phases that come due together across
    // an open-breaker tick latch together; afterwards everything stays frozen.
    drain_results(2);
    send_idle_pct  = 26;
    recv_stall_pct = 87;
    write_setting(16'd100, 16'd0, 16'd60000, 16'd0);
    send_tick(16'd60001, 16'd0, 16'd0, 1'b1);
    send_tick(16'd0, 16'd0, 16'd0, 1'b1);
    send_tick(16'hFFFF, 16'd100, 16'hFFFF, 1'b1);
    send_tick(16'd0, 16'd0, 16'd0, 1'b0);
    send_tick(16'hFFFF, 16'd100, 16'd60001, 1'b1);
    for (k = 0; k < 6; k++) random_tick();

    // wait out the last results, then give the verdict
    drain_results(4);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
